/* rtl/fbib_pkg.sv */
// ---------------------------------------------------------------------------
// fbib_pkg
// shared types and constants of the framebuffer ink bounding box block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbib_pkg;

    localparam int COORD_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int COL_W        = 9;
    localparam int PIX_PER_BYTE = 8;
    localparam int IDX_W        = 3;
    localparam int STRIDE_W     = 10;
    localparam int SAFE_POS_W   = 14;
    localparam int SAFE_LEN_W   = 13;
    localparam int CALC_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_PANEL_DIM = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_W       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_H       = 3'd7;

    localparam logic [1:0] ORIENT_PORTRAIT      = 2'd0;
    localparam logic [1:0] ORIENT_LANDSCAPE_CW  = 2'd1;
    localparam logic [1:0] ORIENT_PORTRAIT_INV  = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_CCW = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COL_W-1:0]   byte_column;
        logic [7:0]         pixel_byte;
        logic               last;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [SIZE_W-1:0]  box_width;
        logic [SIZE_W-1:0]  box_height;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [1:0]         orient;
        logic [COORD_W-1:0] pw;
        logic [COORD_W-1:0] ph;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } region_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
    } merge_t;

endpackage

`default_nettype wire

/* rtl/framebuffer_ink_bounding_box.sv */
// ---------------------------------------------------------------------------
// framebuffer_ink_bounding_box
// bounding box of ink pixels of a 1-bit panel inside a rotated safe region
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+-------------------------------
//  item     | in        | item_valid/stall    | row, byte_column, pixel_byte, last
//  result   | out       | result_valid/stall  | found, box_x/y, box_width/height
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one byte per cycle while item_stall is low; eight pixel lanes test a byte in parallel
//  the last byte runs through stage 1, stage 2 and the finished box to the result word
//  reset clears configuration, the box accumulator and all valids
//  item_stall rises only when a result is stalled on the output and a second
//  one is waiting behind it; cfg_ready is always high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_ink_bounding_box (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output      logic                             item_stall,
    input  wire fbib_pkg::item_t                  item,
    output      logic                             result_valid,
    input  wire logic                             result_stall,
    output      fbib_pkg::result_t                result,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [fbib_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbib_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = fbib_pkg::COORD_W;

    fbib_pkg::region_t region;
    fbib_pkg::merge_t  merged;
    logic              hold;
    logic              row_in;
    logic [fbib_pkg::PIX_PER_BYTE-1:0] hits;

    // stage 1: accepted word
    logic              s1_valid_reg;
    fbib_pkg::item_t   s1_item_reg;

    // stage 2: merged byte
    logic              s2_valid_reg;
    logic              s2_last_reg;
    logic              s2_hit_reg;
    logic [CW-1:0]     s2_xlo_reg;
    logic [CW-1:0]     s2_xhi_reg;
    logic [CW-1:0]     s2_row_reg;

    // accumulator
    logic              ink_seen_reg;
    logic              ink_seen_next;
    logic [CW-1:0]     min_x_reg;
    logic [CW-1:0]     max_x_reg;
    logic [CW-1:0]     min_y_reg;
    logic [CW-1:0]     max_y_reg;
    logic [CW-1:0]     min_x_next;
    logic [CW-1:0]     max_x_next;
    logic [CW-1:0]     min_y_next;
    logic [CW-1:0]     max_y_next;

    // finished physical box
    logic              fin_valid_reg;
    logic              fin_found_reg;
    logic [CW-1:0]     fin_min_x_reg;
    logic [CW-1:0]     fin_max_x_reg;
    logic [CW-1:0]     fin_min_y_reg;
    logic [CW-1:0]     fin_max_y_reg;

    logic              result_valid_reg;
    fbib_pkg::result_t result_reg;
    fbib_pkg::result_t result_next;
    logic [fbib_pkg::SIZE_W-1:0] span_x;
    logic [fbib_pkg::SIZE_W-1:0] span_y;
    logic [CW-1:0]     flip_x;
    logic [CW-1:0]     flip_y;

    fbib_region u_region (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .region    (region)
    );

    assign hold       = fin_valid_reg && result_valid_reg && result_stall;
    assign item_stall = hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    assign row_in = region.ok && (s1_item_reg.row >= region.y0) && (s1_item_reg.row < region.y1);

    // lane 0 is the msb, the leftmost pixel
    for (genvar i = 0; i < fbib_pkg::PIX_PER_BYTE; i++)
    begin : g_lane
        fbib_lane u_lane (
            .enable    (row_in),
            .pixel_bit (s1_item_reg.pixel_byte[fbib_pkg::PIX_PER_BYTE-1-i]),
            .pos_x     ({s1_item_reg.byte_column, fbib_pkg::IDX_W'(i)}),
            .x0        (region.x0),
            .x1        (region.x1),
            .hit       (hits[i])
        );
    end

    fbib_merge u_merge (
        .hits   (hits),
        .merged (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && s1_valid_reg)
        begin
            s2_last_reg <= s1_item_reg.last;
            s2_hit_reg  <= merged.hit;
            s2_xlo_reg  <= {s1_item_reg.byte_column, merged.lo_idx};
            s2_xhi_reg  <= {s1_item_reg.byte_column, merged.hi_idx};
            s2_row_reg  <= s1_item_reg.row;
        end
    end

    always_comb
    begin
        ink_seen_next = ink_seen_reg;
        min_x_next    = min_x_reg;
        max_x_next    = max_x_reg;
        min_y_next    = min_y_reg;
        max_y_next    = max_y_reg;
        if (s2_hit_reg)
        begin
            ink_seen_next = 1'b1;
            if (!ink_seen_reg)
            begin
                min_x_next = s2_xlo_reg;
                max_x_next = s2_xhi_reg;
                min_y_next = s2_row_reg;
                max_y_next = s2_row_reg;
            end
            else
            begin
                min_x_next = (s2_xlo_reg < min_x_reg) ? s2_xlo_reg : min_x_reg;
                max_x_next = (s2_xhi_reg > max_x_reg) ? s2_xhi_reg : max_x_reg;
                min_y_next = (s2_row_reg < min_y_reg) ? s2_row_reg : min_y_reg;
                max_y_next = (s2_row_reg > max_y_reg) ? s2_row_reg : max_y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink_seen_reg  <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            fin_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg && s2_last_reg)
            begin
                ink_seen_reg <= 1'b0;
                min_x_reg    <= '0;
                max_x_reg    <= '0;
                min_y_reg    <= '0;
                max_y_reg    <= '0;
            end
            else if (s2_valid_reg)
            begin
                ink_seen_reg <= ink_seen_next;
                min_x_reg    <= min_x_next;
                max_x_reg    <= max_x_next;
                min_y_reg    <= min_y_next;
                max_y_reg    <= max_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && s2_valid_reg && s2_last_reg)
        begin
            fin_found_reg <= region.ok && ink_seen_next;
            fin_min_x_reg <= min_x_next;
            fin_max_x_reg <= max_x_next;
            fin_min_y_reg <= min_y_next;
            fin_max_y_reg <= max_y_next;
        end
    end

    // map physical corners back to logical space
    always_comb
    begin
        span_x = {1'b0, fin_max_x_reg - fin_min_x_reg} + fbib_pkg::SIZE_W'(1);
        span_y = {1'b0, fin_max_y_reg - fin_min_y_reg} + fbib_pkg::SIZE_W'(1);
        flip_x = region.pw - CW'(1) - fin_max_x_reg;
        flip_y = region.ph - CW'(1) - fin_max_y_reg;
        result_next = '0;
        if (fin_found_reg)
        begin
            result_next.found = 1'b1;
            case (region.orient)
                fbib_pkg::ORIENT_PORTRAIT:
                begin
                    result_next.box_x      = flip_y;
                    result_next.box_y      = fin_min_x_reg;
                    result_next.box_width  = span_y;
                    result_next.box_height = span_x;
                end
                fbib_pkg::ORIENT_LANDSCAPE_CW:
                begin
                    result_next.box_x      = flip_x;
                    result_next.box_y      = flip_y;
                    result_next.box_width  = span_x;
                    result_next.box_height = span_y;
                end
                fbib_pkg::ORIENT_PORTRAIT_INV:
                begin
                    result_next.box_x      = fin_min_y_reg;
                    result_next.box_y      = flip_x;
                    result_next.box_width  = span_y;
                    result_next.box_height = span_x;
                end
                default:
                begin
                    result_next.box_x      = fin_min_x_reg;
                    result_next.box_y      = fin_min_y_reg;
                    result_next.box_width  = span_x;
                    result_next.box_height = span_y;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            if (fin_valid_reg)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && fin_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> fin_valid_reg && result_valid_reg)
        else $error("input stalled with a free result slot");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ink_seen_reg |-> (min_x_reg <= max_x_reg) && (min_y_reg <= max_y_reg))
        else $error("accumulated box corners out of order");

    a_fin_moves: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !result_valid_reg |=> result_valid_reg)
        else $error("finished box did not reach the output register");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.found |-> (result_reg.box_x == '0)
            && (result_reg.box_y == '0) && (result_reg.box_width == '0)
            && (result_reg.box_height == '0))
        else $error("result without ink carries nonzero box");

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.found |-> (result_reg.box_width != '0)
            && (result_reg.box_height != '0))
        else $error("found box has zero size");

endmodule

`default_nettype wire

/* rtl/fbib_region.sv */
// ---------------------------------------------------------------------------
// fbib_region
// configuration registers and the registered panel-space scan region
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbib_region (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [fbib_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbib_pkg::CFG_DATA_W-1:0]  cfg_data,
    output      fbib_pkg::region_t                region
);

    logic [fbib_pkg::COORD_W-1:0]    panel_width_reg;
    logic [fbib_pkg::COORD_W-1:0]    panel_height_reg;
    logic [fbib_pkg::STRIDE_W-1:0]   stride_bytes_reg;
    logic [1:0]                      orientation_reg;
    logic [fbib_pkg::SAFE_POS_W-1:0] safe_x_reg;
    logic [fbib_pkg::SAFE_POS_W-1:0] safe_y_reg;
    logic [fbib_pkg::SAFE_LEN_W-1:0] safe_w_reg;
    logic [fbib_pkg::SAFE_LEN_W-1:0] safe_h_reg;

    fbib_pkg::region_t region_reg;
    fbib_pkg::region_t region_next;

    logic signed [fbib_pkg::CALC_W-1:0] w_s;
    logic signed [fbib_pkg::CALC_W-1:0] h_s;
    logic signed [fbib_pkg::CALC_W-1:0] lx0;
    logic signed [fbib_pkg::CALC_W-1:0] lx1;
    logic signed [fbib_pkg::CALC_W-1:0] ly0;
    logic signed [fbib_pkg::CALC_W-1:0] ly1;
    logic signed [fbib_pkg::CALC_W-1:0] ra;
    logic signed [fbib_pkg::CALC_W-1:0] rb;
    logic signed [fbib_pkg::CALC_W-1:0] rc;
    logic signed [fbib_pkg::CALC_W-1:0] rd;
    logic signed [fbib_pkg::CALC_W-1:0] ra_dn;
    logic signed [fbib_pkg::CALC_W-1:0] rb_up;
    logic [fbib_pkg::SIZE_W-1:0]        bytes_needed;
    logic                               cfg_ok;

    function automatic logic [fbib_pkg::COORD_W-1:0] clamp_edge(
        input logic signed [fbib_pkg::CALC_W-1:0] v,
        input logic [fbib_pkg::COORD_W-1:0]       hi
    );
        logic [fbib_pkg::COORD_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({{(fbib_pkg::CALC_W - fbib_pkg::COORD_W){1'b0}}, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[fbib_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign region    = region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= '0;
            panel_height_reg <= '0;
            stride_bytes_reg <= '0;
            orientation_reg  <= '0;
            safe_x_reg       <= '0;
            safe_y_reg       <= '0;
            safe_w_reg       <= '0;
            safe_h_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fbib_pkg::REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data[fbib_pkg::COORD_W-1:0];
                fbib_pkg::REG_PANEL_HEIGHT: panel_height_reg <= cfg_data[fbib_pkg::COORD_W-1:0];
                fbib_pkg::REG_STRIDE_BYTES: stride_bytes_reg <= cfg_data[fbib_pkg::STRIDE_W-1:0];
                fbib_pkg::REG_ORIENTATION:  orientation_reg  <= cfg_data[1:0];
                fbib_pkg::REG_SAFE_X:       safe_x_reg       <= cfg_data[fbib_pkg::SAFE_POS_W-1:0];
                fbib_pkg::REG_SAFE_Y:       safe_y_reg       <= cfg_data[fbib_pkg::SAFE_POS_W-1:0];
                fbib_pkg::REG_SAFE_W:       safe_w_reg       <= cfg_data[fbib_pkg::SAFE_LEN_W-1:0];
                fbib_pkg::REG_SAFE_H:       safe_h_reg       <= cfg_data[fbib_pkg::SAFE_LEN_W-1:0];
                default:                    panel_width_reg  <= panel_width_reg;
            endcase
        end
    end

    always_comb
    begin
        w_s = $signed({{(fbib_pkg::CALC_W - fbib_pkg::COORD_W){1'b0}}, panel_width_reg});
        h_s = $signed({{(fbib_pkg::CALC_W - fbib_pkg::COORD_W){1'b0}}, panel_height_reg});
        lx0 = $signed({{(fbib_pkg::CALC_W - fbib_pkg::SAFE_POS_W){safe_x_reg[fbib_pkg::SAFE_POS_W-1]}},
                       safe_x_reg});
        ly0 = $signed({{(fbib_pkg::CALC_W - fbib_pkg::SAFE_POS_W){safe_y_reg[fbib_pkg::SAFE_POS_W-1]}},
                       safe_y_reg});
        lx1 = lx0 + $signed({{(fbib_pkg::CALC_W - fbib_pkg::SAFE_LEN_W){1'b0}}, safe_w_reg});
        ly1 = ly0 + $signed({{(fbib_pkg::CALC_W - fbib_pkg::SAFE_LEN_W){1'b0}}, safe_h_reg});

        case (orientation_reg)
            fbib_pkg::ORIENT_PORTRAIT:
            begin
                ra = ly0;       rb = ly1;       rc = h_s - lx1; rd = h_s - lx0;
            end
            fbib_pkg::ORIENT_LANDSCAPE_CW:
            begin
                ra = w_s - lx1; rb = w_s - lx0; rc = h_s - ly1; rd = h_s - ly0;
            end
            fbib_pkg::ORIENT_PORTRAIT_INV:
            begin
                ra = w_s - ly1; rb = w_s - ly0; rc = lx0;       rd = lx1;
            end
            default:
            begin
                ra = lx0;       rb = lx1;       rc = ly0;       rd = ly1;
            end
        endcase

        // round the low x bound down and the high x bound up to byte boundaries
        ra_dn = ra & ~(fbib_pkg::CALC_W'(fbib_pkg::PIX_PER_BYTE - 1));
        rb_up = (rb + fbib_pkg::CALC_W'(fbib_pkg::PIX_PER_BYTE - 1))
                & ~(fbib_pkg::CALC_W'(fbib_pkg::PIX_PER_BYTE - 1));

        bytes_needed = ({1'b0, panel_width_reg} + fbib_pkg::SIZE_W'(fbib_pkg::PIX_PER_BYTE - 1))
                       >> fbib_pkg::IDX_W;

        cfg_ok = (panel_width_reg != '0) && (panel_height_reg != '0)
                 && (panel_width_reg[fbib_pkg::IDX_W-1:0] == '0)
                 && ({1'b0, panel_width_reg} <= fbib_pkg::SIZE_W'(fbib_pkg::MAX_PANEL_DIM))
                 && ({1'b0, panel_height_reg} <= fbib_pkg::SIZE_W'(fbib_pkg::MAX_PANEL_DIM))
                 && ({{(fbib_pkg::SIZE_W - fbib_pkg::STRIDE_W){1'b0}}, stride_bytes_reg}
                     >= bytes_needed)
                 && (safe_w_reg != '0) && (safe_h_reg != '0);

        region_next.orient = orientation_reg;
        region_next.pw     = panel_width_reg;
        region_next.ph     = panel_height_reg;
        region_next.x0     = clamp_edge(ra_dn, panel_width_reg);
        region_next.x1     = clamp_edge(rb_up, panel_width_reg);
        region_next.y0     = clamp_edge(rc, panel_height_reg);
        region_next.y1     = clamp_edge(rd, panel_height_reg);
        region_next.ok     = cfg_ok && (region_next.x1 > region_next.x0)
                             && (region_next.y1 > region_next.y0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= '0;
        end
        else
        begin
            region_reg <= region_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fbib_lane.sv */
// ---------------------------------------------------------------------------
// fbib_lane
// one pixel lane: ink test against the region's x span
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbib_lane (
    input  wire logic                          enable,
    input  wire logic                          pixel_bit,
    input  wire logic [fbib_pkg::COORD_W-1:0]  pos_x,
    input  wire logic [fbib_pkg::COORD_W-1:0]  x0,
    input  wire logic [fbib_pkg::COORD_W-1:0]  x1,
    output      logic                          hit
);

    // zero bit is ink
    assign hit = enable && !pixel_bit && (pos_x >= x0) && (pos_x < x1);

endmodule

`default_nettype wire

/* rtl/fbib_merge.sv */
// ---------------------------------------------------------------------------
// fbib_merge
// combines lane hits into leftmost and rightmost ink index of a byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbib_merge (
    input  wire logic [fbib_pkg::PIX_PER_BYTE-1:0] hits,
    output      fbib_pkg::merge_t                  merged
);

    always_comb
    begin
        merged.hit    = |hits;
        merged.lo_idx = '0;
        merged.hi_idx = '0;
        for (int i = fbib_pkg::PIX_PER_BYTE - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                merged.lo_idx = fbib_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < fbib_pkg::PIX_PER_BYTE; i++)
        begin
            if (hits[i])
            begin
                merged.hi_idx = fbib_pkg::IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire
